>>> hdl/assert_macros.svh
// Assertion macros shared by the rotor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/enr_pkg.sv
// Types, codes and constants for the rotor substitution core.
package enr_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int LETTER_W          = 5;
  localparam int SUM_W             = LETTER_W + 1;
  localparam int ACTION_W          = 2;
  localparam int WIRED_ENTRIES     = 26;
  localparam int WIRE_SLOTS        = 2 ** LETTER_W;
  localparam int MAP_WIDE_W        = 60;
  localparam int MAP_HIGH_W        = 10;
  localparam int NOTCH_W           = 26;
  localparam int LOW_ENTRIES       = 12;
  localparam int MID_ENTRIES       = 12;
  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 60;

  localparam logic [ACTION_W-1:0] ACT_FORWARD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REVERSE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_MID    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HIGH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTCH_MASK = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_POS  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SELF_STEP  = 3'd5;

  typedef struct packed {
    logic [MAP_WIDE_W-1:0] map_low;
    logic [MAP_WIDE_W-1:0] map_mid;
    logic [MAP_HIGH_W-1:0] map_high;
    logic [NOTCH_W-1:0]    notch_mask;
    logic                  self_stepping;
  } rotor_cfg_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic                notch_hit;
    logic [LETTER_W-1:0] rotor_position;
    logic                not_found;
  } rotor_result_t;

endpackage

>>> hdl/enigma_rotor_substitution_core.sv
// Rotor substitution core: one input beat per cycle while item_stall is low,
// one result beat per input beat. An accepted beat is held in an input
// register, passes the combinational substitution logic and lands in the
// result register, which holds it on the outputs until taken. Throughput is
// one beat per cycle when the output is not stalled, set by the single
// combinational pass (reverse lookup is 26 parallel compares on the wiring
// registers). The input register also absorbs one beat while a result waits.
// The configuration port is always ready; writing start_position also loads
// the rotor position.
`include "assert_macros.svh"

module enigma_rotor_substitution_core #(
  parameter int ALPHABET_SIZE = enr_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [enr_pkg::ACTION_W-1:0]    action,
  input  logic [enr_pkg::LETTER_W-1:0]    letter_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [enr_pkg::LETTER_W-1:0]    letter_out,
  output logic                            notch_hit,
  output logic [enr_pkg::LETTER_W-1:0]    rotor_position,
  output logic                            not_found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [enr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [enr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW = enr_pkg::LETTER_W;

  enr_pkg::rotor_cfg_t    cfg;
  enr_pkg::rotor_result_t subst_res;
  enr_pkg::rotor_result_t result;

  logic [LW-1:0]                start_mod;
  logic [LW-1:0]                position;
  logic                         notch_latched;
  logic                         s1_valid;
  logic [enr_pkg::ACTION_W-1:0] s1_action;
  logic [LW-1:0]                s1_letter;
  logic                         out_free;
  logic                         move;
  logic                         accept;
  logic                         cfg_write;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign out_free   = !result_valid || !result_stall;
  assign move       = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  enr_modn #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_mod_start (
    .value  (enr_pkg::SUM_W'(cfg_data[LW-1:0])),
    .result (start_mod)
  );

  enr_subst #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_subst (
    .action        (s1_action),
    .letter_in     (s1_letter),
    .cfg           (cfg),
    .position      (position),
    .notch_latched (notch_latched),
    .result        (subst_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        enr_pkg::REG_MAP_LOW:    cfg.map_low       <= cfg_data[enr_pkg::MAP_WIDE_W-1:0];
        enr_pkg::REG_MAP_MID:    cfg.map_mid       <= cfg_data[enr_pkg::MAP_WIDE_W-1:0];
        enr_pkg::REG_MAP_HIGH:   cfg.map_high      <= cfg_data[enr_pkg::MAP_HIGH_W-1:0];
        enr_pkg::REG_NOTCH_MASK: cfg.notch_mask    <= cfg_data[enr_pkg::NOTCH_W-1:0];
        enr_pkg::REG_SELF_STEP:  cfg.self_stepping <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      notch_latched <= 1'b0;
    end else if (cfg_write && cfg_index == enr_pkg::REG_START_POS) begin
      position <= start_mod;
    end else if (move) begin
      position      <= subst_res.rotor_position;
      notch_latched <= subst_res.notch_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_letter <= letter_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result <= subst_res;
    end
  end

  assign letter_out     = result.letter_out;
  assign notch_hit      = result.notch_hit;
  assign rotor_position = result.rotor_position;
  assign not_found      = result.not_found;

  `ASSERT_IMPLIES(a_pos_range, clk, rst, 1'b1, {1'b0, position} < 6'(ALPHABET_SIZE), "rotor position out of range")
  `ASSERT_NEXT(a_rev_holds_pos, clk, rst, move && s1_action == enr_pkg::ACT_REVERSE && !cfg_write, position == $past(position) && notch_latched == $past(notch_latched), "reverse beat changed rotor state")
  `ASSERT_IMPLIES(a_missing_zero, clk, rst, result_valid && result.not_found, result.letter_out == '0, "missing entry with nonzero letter")
  `ASSERT_IMPLIES(a_stall_full, clk, rst, item_stall, s1_valid && result_valid, "input stalled with free buffer")

endmodule

>>> hdl/enr_modn.sv
// Reduction of a small sum modulo the alphabet size through a constant table.
module enr_modn #(
  parameter int ALPHABET_SIZE = enr_pkg::ALPHABET_SIZE_DEF
) (
  input  logic [enr_pkg::SUM_W-1:0]    value,
  output logic [enr_pkg::LETTER_W-1:0] result
);

  localparam int TABLE_DEPTH = 2 ** enr_pkg::SUM_W;

  logic [enr_pkg::LETTER_W-1:0] mod_table [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_table
    localparam logic [enr_pkg::LETTER_W-1:0] ENTRY =
      enr_pkg::LETTER_W'(g % ALPHABET_SIZE);
    assign mod_table[g] = ENTRY;
  end

  assign result = mod_table[value];

endmodule

>>> hdl/enr_subst.sv
// Single-pass forward, reverse and step logic of the rotor.
module enr_subst #(
  parameter int ALPHABET_SIZE = enr_pkg::ALPHABET_SIZE_DEF
) (
  input  logic [enr_pkg::ACTION_W-1:0] action,
  input  logic [enr_pkg::LETTER_W-1:0] letter_in,
  input  enr_pkg::rotor_cfg_t          cfg,
  input  logic [enr_pkg::LETTER_W-1:0] position,
  input  logic                         notch_latched,
  output enr_pkg::rotor_result_t       result
);

  localparam int LW = enr_pkg::LETTER_W;
  localparam int SW = enr_pkg::SUM_W;
  localparam int NW = enr_pkg::WIRED_ENTRIES;
  localparam int LOW_END = enr_pkg::LOW_ENTRIES;
  localparam int MID_END = enr_pkg::LOW_ENTRIES + enr_pkg::MID_ENTRIES;

  logic [LW-1:0]            wiring [enr_pkg::WIRE_SLOTS];
  logic [NW-1:0]            match;
  logic [LW-1:0]            pos_adv;
  logic [LW-1:0]            pos_use;
  logic [LW-1:0]            shifted;
  logic [LW-1:0]            fwd_letter;
  logic [LW-1:0]            rev_letter;
  logic [LW-1:0]            found_idx;
  logic                     found;
  logic [enr_pkg::WIRE_SLOTS-1:0] notch_wide;

  for (genvar g = 0; g < enr_pkg::WIRE_SLOTS; g++) begin : g_wiring
    if (g < LOW_END) begin : g_low
      assign wiring[g] = cfg.map_low[LW*g +: LW];
    end else if (g < MID_END) begin : g_mid
      assign wiring[g] = cfg.map_mid[LW*(g-LOW_END) +: LW];
    end else if (g < NW) begin : g_high
      assign wiring[g] = cfg.map_high[LW*(g-MID_END) +: LW];
    end else begin : g_none
      assign wiring[g] = '0;
    end
  end

  enr_modn #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_mod_step (
    .value  (SW'(position) + SW'(1)),
    .result (pos_adv)
  );

  assign pos_use = (action == enr_pkg::ACT_FORWARD && cfg.self_stepping) ? pos_adv : position;

  enr_modn #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_mod_shift (
    .value  (SW'(letter_in) + SW'(pos_use)),
    .result (shifted)
  );

  enr_modn #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_mod_fwd (
    .value  (SW'(wiring[shifted]) + SW'(ALPHABET_SIZE) - SW'(pos_use)),
    .result (fwd_letter)
  );

  for (genvar g = 0; g < NW; g++) begin : g_match
    assign match[g] = (g < ALPHABET_SIZE) && (wiring[g] == shifted);
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_idx = LW'(i);
      end
    end
  end

  enr_modn #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_mod_rev (
    .value  (SW'(found_idx) + SW'(ALPHABET_SIZE) - SW'(position)),
    .result (rev_letter)
  );

  assign notch_wide = enr_pkg::WIRE_SLOTS'(cfg.notch_mask);

  always_comb begin
    result.letter_out     = '0;
    result.notch_hit      = notch_latched;
    result.rotor_position = position;
    result.not_found      = 1'b0;
    case (action)
      enr_pkg::ACT_FORWARD: begin
        result.letter_out     = fwd_letter;
        result.notch_hit      = notch_wide[pos_use];
        result.rotor_position = pos_use;
      end
      enr_pkg::ACT_REVERSE: begin
        result.letter_out = found ? rev_letter : '0;
        result.not_found  = ~found;
      end
      enr_pkg::ACT_STEP: begin
        result.rotor_position = pos_adv;
      end
      default: begin
        result.letter_out = '0;
      end
    endcase
  end

endmodule
